// ===== hdl/smat_pkg.sv =====
package smat_pkg;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int IN_IDX_W  = 3;
    localparam int IN_VAL_W  = 16;
    localparam int OUT_IDX_W = 3;
    localparam int VAL_W     = 35;

    localparam logic [2:0] FUNC_WRITE_A   = 3'd0;
    localparam logic [2:0] FUNC_WRITE_B   = 3'd1;
    localparam logic [2:0] FUNC_SUM       = 3'd2;
    localparam logic [2:0] FUNC_PRODUCT   = 3'd3;
    localparam logic [2:0] FUNC_TRANSPOSE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    typedef enum logic [1:0] {
        OP_SUM,
        OP_PRODUCT,
        OP_TRANSPOSE
    } op_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

    typedef struct packed {
        logic                 valid;
        op_t                  op;
        logic                 first;
        logic                 last_k;
        logic                 last_elem;
        logic [OUT_IDX_W-1:0] row;
        logic [OUT_IDX_W-1:0] col;
    } issue_t;

endpackage

// ===== hdl/smat_seq.sv =====
module smat_seq
    import smat_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          launch,
    input  op_t                           launch_op,
    input  logic [$clog2(MAX_DIM+1)-1:0]  ar,
    input  logic [$clog2(MAX_DIM+1)-1:0]  ac,
    input  logic [$clog2(MAX_DIM+1)-1:0]  bc,
    output issue_t                        issue,
    output logic [2*$clog2(MAX_DIM)-1:0]  a_addr,
    output logic [2*$clog2(MAX_DIM)-1:0]  b_addr
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DIM_W = $clog2(MAX_DIM + 1);

    seq_state_t       state_reg, state_next;
    op_t              op_reg, op_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] i_last_reg, i_last_next;
    logic [IDX_W-1:0] j_last_reg, j_last_next;
    logic [IDX_W-1:0] k_last_reg, k_last_next;
    logic             i_end, j_end, k_end;

    function automatic logic [IDX_W-1:0] last_of(input logic [DIM_W-1:0] d);
        return IDX_W'(d - DIM_W'(1));
    endfunction

    assign i_end = (i_reg == i_last_reg);
    assign j_end = (j_reg == j_last_reg);
    assign k_end = (k_reg == k_last_reg);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        i_last_next = i_last_reg;
        j_last_next = j_last_reg;
        k_last_next = k_last_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (launch)
                begin
                    state_next = SEQ_RUN;
                    op_next    = launch_op;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    case (launch_op)
                        OP_PRODUCT:
                        begin
                            i_last_next = last_of(ar);
                            j_last_next = last_of(bc);
                            k_last_next = last_of(ac);
                        end
                        OP_TRANSPOSE:
                        begin
                            i_last_next = last_of(ac);
                            j_last_next = last_of(ar);
                            k_last_next = '0;
                        end
                        default:
                        begin
                            i_last_next = last_of(ar);
                            j_last_next = last_of(ac);
                            k_last_next = '0;
                        end
                    endcase
                end
            end
            SEQ_RUN:
            begin
                if (k_end)
                begin
                    k_next = '0;
                    if (j_end)
                    begin
                        j_next = '0;
                        if (i_end)
                        begin
                            state_next = SEQ_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        i_last_reg <= i_last_next;
        j_last_reg <= j_last_next;
        k_last_reg <= k_last_next;
    end

    always_comb
    begin
        case (op_reg)
            OP_PRODUCT:
            begin
                a_addr = {i_reg, k_reg};
                b_addr = {k_reg, j_reg};
            end
            OP_TRANSPOSE:
            begin
                a_addr = {j_reg, i_reg};
                b_addr = {j_reg, i_reg};
            end
            default:
            begin
                a_addr = {i_reg, j_reg};
                b_addr = {i_reg, j_reg};
            end
        endcase
    end

    assign issue.valid     = (state_reg == SEQ_RUN);
    assign issue.op        = op_reg;
    assign issue.first     = (k_reg == '0);
    assign issue.last_k    = k_end;
    assign issue.last_elem = i_end && j_end;
    assign issue.row       = OUT_IDX_W'(i_reg);
    assign issue.col       = OUT_IDX_W'(j_reg);

endmodule

// ===== hdl/small_matrix_add_mul_transpose_core.sv =====
// A write transaction gives no result; busy stays low.
// A sum or transpose streams one element per cycle.
// A product accumulates a_cols products per element on the single shared multiplier,
// so it streams its elements more slowly, and busy stays high until the last one is emitted.
// A size mismatch gives its error result in the cycle after start; results cannot be stalled.
// Reset sets all four size registers to one; the matrix memories hold no defined value.
module small_matrix_add_mul_transpose_core
    import smat_pkg::*;
#(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  func,
    input  logic [IN_IDX_W-1:0]         row_index,
    input  logic [IN_IDX_W-1:0]         col_index,
    input  logic signed [IN_VAL_W-1:0]  element_value,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    output logic                        result_valid,
    output logic [OUT_IDX_W-1:0]        out_row,
    output logic [OUT_IDX_W-1:0]        out_col,
    output logic signed [VAL_W-1:0]     out_value,
    output logic                        last_element,
    output logic                        status
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int PW     = 2 * ELEM_WIDTH;
    localparam int XW     = (PW > VAL_W) ? PW : VAL_W;

    logic [CFG_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [DIM_W-1:0] ar, ac, br, bc;

    logic             accept;
    logic             is_op;
    logic             mismatch;
    logic             launch;
    op_t              launch_op;
    logic             wr_ok;
    logic             a_we, b_we;
    logic [ADDR_W-1:0] w_addr;
    logic signed [ELEM_WIDTH-1:0] w_data;

    issue_t            issue;
    logic [ADDR_W-1:0] a_addr, b_addr;

    logic signed [ELEM_WIDTH-1:0] mem_a [DEPTH];
    logic signed [ELEM_WIDTH-1:0] mem_b [DEPTH];
    logic signed [ELEM_WIDTH-1:0] a_rd_reg, b_rd_reg;

    issue_t            s1_ctl_reg, s2_ctl_reg;
    logic signed [PW-1:0] prod;
    logic signed [XW-1:0] x_val;
    logic [VAL_W-1:0]  s2_val_reg, s2_val_next;
    logic [VAL_W-1:0]  acc_reg, acc_next;
    logic              emit;

    logic              busy_reg, busy_next;
    logic              result_valid_reg, result_valid_next;
    logic [OUT_IDX_W-1:0] out_row_reg, out_col_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              last_element_reg, status_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            return DIM_W'(MAX_DIM);
        end
        else
        begin
            return DIM_W'(v);
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= CFG_W'(1);
            a_cols_reg <= CFG_W'(1);
            b_rows_reg <= CFG_W'(1);
            b_cols_reg <= CFG_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_A_ROWS: a_rows_reg <= cfg_data;
                REG_A_COLS: a_cols_reg <= cfg_data;
                REG_B_ROWS: b_rows_reg <= cfg_data;
                REG_B_COLS: b_cols_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign ar = clamp_dim(a_rows_reg);
    assign ac = clamp_dim(a_cols_reg);
    assign br = clamp_dim(b_rows_reg);
    assign bc = clamp_dim(b_cols_reg);

    assign accept = start && !busy_reg;

    always_comb
    begin
        is_op     = 1'b0;
        mismatch  = 1'b0;
        launch_op = OP_SUM;
        case (func)
            FUNC_SUM:
            begin
                is_op    = 1'b1;
                mismatch = (ar != br) || (ac != bc);
            end
            FUNC_PRODUCT:
            begin
                is_op     = 1'b1;
                launch_op = OP_PRODUCT;
                mismatch  = (br != ac);
            end
            FUNC_TRANSPOSE:
            begin
                is_op     = 1'b1;
                launch_op = OP_TRANSPOSE;
            end
            default:
            begin
                is_op = 1'b0;
            end
        endcase
    end

    assign launch = accept && is_op && !mismatch;

    assign wr_ok  = accept && (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
    assign a_we   = wr_ok && (func == FUNC_WRITE_A);
    assign b_we   = wr_ok && (func == FUNC_WRITE_B);
    assign w_addr = {IDX_W'(row_index), IDX_W'(col_index)};
    assign w_data = ELEM_WIDTH'(element_value);

    smat_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .launch    (launch),
        .launch_op (launch_op),
        .ar        (ar),
        .ac        (ac),
        .bc        (bc),
        .issue     (issue),
        .a_addr    (a_addr),
        .b_addr    (b_addr)
    );

    // Writes are only taken while busy is low, so a write never coincides with an operation's reads.
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            mem_a[w_addr] <= w_data;
        end
        a_rd_reg <= mem_a[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            mem_b[w_addr] <= w_data;
        end
        b_rd_reg <= mem_b[b_addr];
    end

    assign prod = PW'(a_rd_reg) * PW'(b_rd_reg);

    always_comb
    begin
        case (s1_ctl_reg.op)
            OP_PRODUCT:   x_val = XW'(prod);
            OP_TRANSPOSE: x_val = XW'(a_rd_reg);
            default:      x_val = XW'(a_rd_reg) + XW'(b_rd_reg);
        endcase
        s2_val_next = x_val[VAL_W-1:0];
    end

    assign acc_next = s2_ctl_reg.first ? s2_val_reg : (acc_reg + s2_val_reg);
    assign emit     = s2_ctl_reg.valid && s2_ctl_reg.last_k;

    always_comb
    begin
        busy_next = busy_reg;
        if (launch)
        begin
            busy_next = 1'b1;
        end
        else if (emit && s2_ctl_reg.last_elem)
        begin
            busy_next = 1'b0;
        end
        result_valid_next = emit || (accept && is_op && mismatch);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            s1_ctl_reg       <= '0;
            s2_ctl_reg       <= '0;
        end
        else
        begin
            busy_reg         <= busy_next;
            result_valid_reg <= result_valid_next;
            s1_ctl_reg       <= issue;
            s2_ctl_reg       <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_val_reg <= s2_val_next;
        if (s2_ctl_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (emit)
        begin
            out_row_reg      <= s2_ctl_reg.row;
            out_col_reg      <= s2_ctl_reg.col;
            out_value_reg    <= acc_next;
            last_element_reg <= s2_ctl_reg.last_elem;
            status_reg       <= 1'b0;
        end
        else if (accept && is_op && mismatch)
        begin
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            out_value_reg    <= '0;
            last_element_reg <= 1'b1;
            status_reg       <= 1'b1;
        end
    end

    assign busy         = busy_reg;
    assign result_valid = result_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign out_value    = $signed(out_value_reg);
    assign last_element = last_element_reg;
    assign status       = status_reg;

endmodule

// ===== hdl/smat_chk.sv =====
module smat_chk
    import smat_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [2:0]                 func,
    input logic                       result_valid,
    input logic [OUT_IDX_W-1:0]       out_row,
    input logic [OUT_IDX_W-1:0]       out_col,
    input logic signed [VAL_W-1:0]    out_value,
    input logic                       last_element,
    input logic                       status
);

    // The final result of an operation and the drop of busy come together.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid && last_element && !status)
        else $error("busy dropped without a final result");

    // An error result is a lone, zeroed transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |->
            last_element && out_value == '0 && out_row == '0 && out_col == '0)
        else $error("malformed error result");

    // A result that is not the last one comes only while an operation runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_element |-> busy)
        else $error("intermediate result while idle");

    // Writes and unused codes produce no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && func != FUNC_SUM && func != FUNC_PRODUCT
            && func != FUNC_TRANSPOSE |=> !result_valid)
        else $error("result after a transaction that yields none");

endmodule

bind small_matrix_add_mul_transpose_core smat_chk u_smat_chk (.*);
